>>> rtl/core/wsld_pkg.sv
package wsld_pkg;

    localparam int MaxRes   = 4;
    localparam int FifoDepth = 8;
    localparam int FifoAw   = $clog2(FifoDepth);
    localparam int FifoCw   = FifoAw + 1;

    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChApos  = 8'h27;
    localparam logic [7:0] ChBsl   = 8'h5C;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChOne   = 8'h31;
    localparam logic [7:0] ChSeven = 8'h37;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChLowA  = 8'h61;
    localparam logic [7:0] ChLowF  = 8'h66;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpF   = 8'h46;
    localparam logic [7:0] ChLowN  = 8'h6E;
    localparam logic [7:0] ChLowT  = 8'h74;
    localparam logic [7:0] ChLowR  = 8'h72;
    localparam logic [7:0] ChLowX  = 8'h78;

    typedef enum logic [1:0] {
        PH_SEEK   = 2'd0,
        PH_INSIDE = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_BSL  = 2'd1,
        ESC_HEX  = 2'd2,
        ESC_OCT  = 2'd3
    } esc_t;

    typedef struct packed {
        phase_t      phase;
        esc_t        esc;
        logic [63:0] acc;
        logic [1:0]  oct_cnt;
        logic [7:0]  lead;
        logic [7:0]  held0;
        logic [7:0]  held1;
        logic [1:0]  held_cnt;
    } dec_state_t;

    typedef struct packed {
        logic [2:0]               n;
        logic [MaxRes-1:0]        last;
        logic [MaxRes-1:0][63:0]  val;
    } res_set_t;

    typedef struct packed {
        dec_state_t st;
        res_set_t   rs;
    } dec_ctx_t;

    function automatic dec_state_t state_reset();
        dec_state_t s;
        s.phase    = PH_SEEK;
        s.esc      = ESC_NONE;
        s.acc      = '0;
        s.oct_cnt  = '0;
        s.lead     = '0;
        s.held0    = '0;
        s.held1    = '0;
        s.held_cnt = '0;
        return s;
    endfunction

    function automatic dec_ctx_t push_res(dec_ctx_t c, logic [63:0] v, logic l);
        dec_ctx_t r;
        r = c;
        if (r.rs.n < 3'(MaxRes))
        begin
            r.rs.val[r.rs.n[1:0]]  = v;
            r.rs.last[r.rs.n[1:0]] = l;
            r.rs.n = r.rs.n + 3'd1;
        end
        return r;
    endfunction

    function automatic logic [1:0] conts_needed(logic [7:0] lead);
        logic [1:0] need;
        if ((lead & 8'hE0) == 8'hC0)
            need = 2'd1;
        else if ((lead & 8'hF0) == 8'hE0)
            need = 2'd2;
        else
            need = 2'd3;
        return need;
    endfunction

    // {is_digit, digit}
    function automatic logic [4:0] hex_val(logic [7:0] b);
        logic [4:0] h;
        if (b >= ChZero && b <= ChNine)
            h = {1'b1, b[3:0]};
        else if ((b >= ChLowA && b <= ChLowF) || (b >= ChUpA && b <= ChUpF))
            h = {1'b1, b[3:0] + 4'd9};
        else
            h = 5'd0;
        return h;
    endfunction

    function automatic dec_ctx_t plain_byte(dec_ctx_t c, logic [7:0] b);
        dec_ctx_t r;
        r = c;
        if (b == ChQuote)
        begin
            r = push_res(r, 64'd0, 1'b1);
            r.st.phase = PH_DONE;
        end
        else if (b == ChBsl)
            r.st.esc = ESC_BSL;
        else if (!b[7])
            r = push_res(r, 64'(b), 1'b0);
        else if ((b & 8'hE0) == 8'hC0 || (b & 8'hF0) == 8'hE0 || (b & 8'hF8) == 8'hF0)
        begin
            r.st.lead     = b;
            r.st.held_cnt = 2'd0;
        end
        else
            r = push_res(r, 64'(b), 1'b0);
        return r;
    endfunction

    function automatic dec_ctx_t inside_byte(dec_ctx_t c, logic [7:0] b);
        dec_ctx_t    r;
        logic [1:0]  need;
        logic [63:0] v;
        logic [4:0]  h;
        r = c;
        need = conts_needed(r.st.lead);
        h = hex_val(b);
        v = '0;
        if (r.st.lead != 8'd0)
        begin
            if ({1'b0, r.st.held_cnt} + 3'd1 < {1'b0, need})
            begin
                if (r.st.held_cnt[0])
                    r.st.held1 = b;
                else
                    r.st.held0 = b;
                r.st.held_cnt = r.st.held_cnt + 2'd1;
            end
            else
            begin
                if (need == 2'd1)
                    v = 64'({r.st.lead[4:0], b[5:0]});
                else if (need == 2'd2)
                    v = 64'({r.st.lead[3:0], r.st.held0[5:0], b[5:0]});
                else
                    v = 64'({r.st.lead[2:0], r.st.held0[5:0], r.st.held1[5:0], b[5:0]});
                r = push_res(r, v, 1'b0);
                r.st.lead     = '0;
                r.st.held_cnt = '0;
                r.st.held0    = '0;
                r.st.held1    = '0;
            end
        end
        else
        begin
            unique case (r.st.esc)
                ESC_BSL:
                begin
                    r.st.esc = ESC_NONE;
                    if (b == ChLowN)
                        r = push_res(r, 64'd10, 1'b0);
                    else if (b == ChLowT)
                        r = push_res(r, 64'd9, 1'b0);
                    else if (b == ChLowR)
                        r = push_res(r, 64'd13, 1'b0);
                    else if (b == ChLowA)
                        r = push_res(r, 64'd7, 1'b0);
                    else if (b == ChZero)
                        r = push_res(r, 64'd0, 1'b0);
                    else if (b == ChBsl || b == ChApos || b == ChQuote)
                        r = push_res(r, 64'(b), 1'b0);
                    else if (b == ChLowX)
                    begin
                        r.st.esc = ESC_HEX;
                        r.st.acc = '0;
                    end
                    else if (b >= ChOne && b <= ChSeven)
                    begin
                        r.st.esc     = ESC_OCT;
                        r.st.acc     = 64'(b[2:0]);
                        r.st.oct_cnt = 2'd1;
                    end
                    else
                        r = push_res(r, 64'(b), 1'b0);
                end
                ESC_HEX:
                begin
                    if (h[4])
                        r.st.acc = {r.st.acc[59:0], h[3:0]};
                    else
                    begin
                        r = push_res(r, r.st.acc, 1'b0);
                        r.st.esc = ESC_NONE;
                        r.st.acc = '0;
                        r = plain_byte(r, b);
                    end
                end
                ESC_OCT:
                begin
                    if (b >= ChZero && b <= ChSeven && r.st.oct_cnt != 2'd3)
                    begin
                        r.st.acc     = {r.st.acc[60:0], b[2:0]};
                        r.st.oct_cnt = r.st.oct_cnt + 2'd1;
                        if (r.st.oct_cnt == 2'd3)
                        begin
                            r = push_res(r, r.st.acc, 1'b0);
                            r.st.esc     = ESC_NONE;
                            r.st.acc     = '0;
                            r.st.oct_cnt = '0;
                        end
                    end
                    else
                    begin
                        r = push_res(r, r.st.acc, 1'b0);
                        r.st.esc     = ESC_NONE;
                        r.st.acc     = '0;
                        r.st.oct_cnt = '0;
                        r = plain_byte(r, b);
                    end
                end
                default:
                    r = plain_byte(r, b);
            endcase
        end
        return r;
    endfunction

    function automatic dec_ctx_t text_byte_in(dec_ctx_t c, logic [7:0] b);
        dec_ctx_t r;
        r = c;
        if (r.st.phase == PH_SEEK)
        begin
            if (b == ChQuote)
                r.st.phase = PH_INSIDE;
        end
        else if (r.st.phase == PH_INSIDE)
            r = inside_byte(r, b);
        return r;
    endfunction

    // Emit an open lead raw and feed its held bytes back through the decoder.
    function automatic dec_ctx_t eot_unwind(dec_ctx_t c);
        dec_ctx_t   r;
        logic [7:0] h0;
        logic [7:0] h1;
        logic [1:0] n;
        r = c;
        h0 = r.st.held0;
        h1 = r.st.held1;
        n  = r.st.held_cnt;
        if (r.st.phase == PH_INSIDE && r.st.lead != 8'd0)
        begin
            r = push_res(r, 64'(r.st.lead), 1'b0);
            r.st.lead     = '0;
            r.st.held_cnt = '0;
            r.st.held0    = '0;
            r.st.held1    = '0;
            if (n > 2'd0 && r.st.phase == PH_INSIDE)
                r = inside_byte(r, h0);
            if (n > 2'd1 && r.st.phase == PH_INSIDE)
                r = inside_byte(r, h1);
        end
        return r;
    endfunction

    // Held bytes shrink on every unwind, so three passes always close the lead.
    function automatic dec_ctx_t end_of_text(dec_ctx_t c);
        dec_ctx_t r;
        r = c;
        if (r.st.phase == PH_SEEK)
            r = push_res(r, 64'd0, 1'b1);
        for (int k = 0; k < 3; k++)
            r = eot_unwind(r);
        if (r.st.phase == PH_INSIDE)
        begin
            if (r.st.esc == ESC_BSL)
                r = push_res(r, 64'(ChBsl), 1'b0);
            else if (r.st.esc == ESC_HEX || r.st.esc == ESC_OCT)
                r = push_res(r, r.st.acc, 1'b0);
            r = push_res(r, 64'd0, 1'b1);
        end
        r.st = state_reset();
        return r;
    endfunction

endpackage

>>> rtl/core/wsld_res_fifo.sv
module wsld_res_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  wsld_pkg::res_set_t    wr_set,
    output logic                  room,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output logic [63:0]           rd_value,
    output logic                  rd_last
);

    logic [64:0]                     mem_reg [wsld_pkg::FifoDepth];
    logic [wsld_pkg::FifoAw-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [wsld_pkg::FifoAw-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [wsld_pkg::FifoCw-1:0]     count_reg, count_next;
    logic                            pop;
    logic [wsld_pkg::FifoCw-1:0]     n_in;

    assign room     = count_reg <= wsld_pkg::FifoCw'(wsld_pkg::FifoDepth - wsld_pkg::MaxRes);
    assign rd_valid = count_reg != '0;
    assign pop      = rd_valid && rd_ready;
    assign rd_value = mem_reg[rd_ptr_reg][63:0];
    assign rd_last  = mem_reg[rd_ptr_reg][64];
    assign n_in     = wr_en ? wsld_pkg::FifoCw'(wr_set.n) : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_in[wsld_pkg::FifoAw-1:0];
        rd_ptr_next = rd_ptr_reg + wsld_pkg::FifoAw'(pop);
        count_next  = count_reg + n_in - wsld_pkg::FifoCw'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // a set of up to MaxRes results lands in consecutive slots
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int i = 0; i < wsld_pkg::MaxRes; i++)
            begin
                if (3'(i) < wr_set.n)
                    mem_reg[wr_ptr_reg + wsld_pkg::FifoAw'(i)] <= {wr_set.last[i], wr_set.val[i]};
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= wsld_pkg::FifoCw'(wsld_pkg::FifoDepth))
        else $error("result fifo count out of range");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> room)
        else $error("result set written without room");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty fifo with unequal pointers");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> count_reg == $past(count_reg) + $past(n_in)
                         - wsld_pkg::FifoCw'($past(pop)))
        else $error("fifo count does not follow transfers");

endmodule

>>> rtl/core/wide_string_literal_decoder_unit.sv
// Channel  Direction  Handshake            Payload
// in       sink       in_valid/in_ready    kind, text_byte
// out      source     out_valid/out_ready  code_value, last
//
// One input byte is taken per cycle while in_ready is high; its results (0 to 4)
// are queued, then show on out one per cycle while out_ready is high.
// The input register frees whenever the 8-entry result queue holds 4 or fewer
// results, so the input rate is set by how fast out drains the queue.
// Reset clears the decoder state and empties the queue; out stalls only back up in.
module wide_string_literal_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] code_value,
    output logic        last
);

    logic                  in_valid_reg;
    logic                  kind_reg;
    logic [7:0]            byte_reg;
    wsld_pkg::dec_state_t  state_reg, state_next;
    wsld_pkg::dec_ctx_t    ctx_in, ctx_out;
    logic                  fifo_room;
    logic                  fire;

    assign fire     = in_valid_reg && fifo_room;
    assign in_ready = !in_valid_reg || fire;

    always_comb
    begin
        ctx_in.st = state_reg;
        ctx_in.rs = '0;
        if (kind_reg || byte_reg == 8'd0)
            ctx_out = wsld_pkg::end_of_text(ctx_in);
        else
            ctx_out = wsld_pkg::text_byte_in(ctx_in, byte_reg);
        state_next = fire ? ctx_out.st : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= wsld_pkg::state_reset();
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            byte_reg <= text_byte;
        end
    end

    wsld_res_fifo u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fire),
        .wr_set   (ctx_out.rs),
        .room     (fifo_room),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_value (code_value),
        .rd_last  (last)
    );

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && kind_reg |=> state_reg.phase == wsld_pkg::PH_SEEK && state_reg.lead == 8'd0)
        else $error("end of text left decoder state open");

    a_seek_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == wsld_pkg::PH_SEEK |-> state_reg.esc == wsld_pkg::ESC_NONE
                                               && state_reg.lead == 8'd0)
        else $error("escape or sequence open outside a literal");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(byte_reg) && $stable(kind_reg))
        else $error("held input byte lost while queue full");

endmodule

>>> tb/sv/wide_string_literal_decoder_unit_tb.sv
`timescale 1ns / 1ps

module wide_string_literal_decoder_unit_tb;

    localparam logic [7:0] QUOTE      = 8'h22;
    localparam logic [7:0] BACKSLASH  = 8'h5C;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         LONG_HOLD   = 120;
    localparam int         TAIL_CYCLES = 16;

    typedef struct {
        logic       kind;
        logic [7:0] ch;
        bit         drain;
    } text_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic        last;
    } code_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [7:0]  text_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] code_value;
    logic        last;

    text_item_t pending[$];
    code_t      expected_codes[$];
    int         error_count = 0;

    // decoder state mirror
    wsld_pkg::phase_t lit_phase;
    wsld_pkg::esc_t   esc_state;
    logic [63:0]      esc_acc;
    logic [1:0]       oct_count;
    logic [7:0]       u8_lead;
    logic [7:0]       u8_held [2];
    logic [1:0]       u8_count;
    int               step_codes;

    wide_string_literal_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .text_byte  (text_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_value (code_value),
        .last       (last)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    function automatic void clear_decoder();
        lit_phase  = wsld_pkg::PH_SEEK;
        esc_state  = wsld_pkg::ESC_NONE;
        esc_acc    = '0;
        oct_count  = '0;
        u8_lead    = '0;
        u8_held[0] = '0;
        u8_held[1] = '0;
        u8_count   = '0;
    endfunction

    function automatic void emit_code(logic [63:0] v, logic l);
        code_t c;
        if (step_codes < wsld_pkg::MaxRes)
        begin
            c.value = v;
            c.last  = l;
            expected_codes.insert(expected_codes.size(), c);
            step_codes++;
        end
    endfunction

    function automatic int utf8_tail_len(logic [7:0] lead);
        if (lead[7:5] == 3'b110)
            return 1;
        if (lead[7:4] == 4'b1110)
            return 2;
        return 3;
    endfunction

    function automatic int hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9")
            return b - "0";
        if (b >= "a" && b <= "f")
            return b - "a" + 10;
        if (b >= "A" && b <= "F")
            return b - "A" + 10;
        return -1;
    endfunction

    function automatic void decode_plain(logic [7:0] b);
        if (b == QUOTE)
        begin
            emit_code(64'd0, 1'b1);
            lit_phase = wsld_pkg::PH_DONE;
        end
        else if (b == BACKSLASH)
            esc_state = wsld_pkg::ESC_BSL;
        else if (!b[7])
            emit_code(64'(b), 1'b0);
        else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110)
        begin
            u8_lead  = b;
            u8_count = '0;
        end
        else
            emit_code(64'(b), 1'b0);
    endfunction

    function automatic void decode_inside(logic [7:0] b);
        int          need;
        int          d;
        logic [63:0] v;
        if (u8_lead != 8'd0)
        begin
            need = utf8_tail_len(u8_lead);
            if (int'(u8_count) + 1 < need)
            begin
                u8_held[u8_count[0]] = b;
                u8_count++;
                return;
            end
            if (need == 1)
                v = 64'({u8_lead[4:0], b[5:0]});
            else if (need == 2)
                v = 64'({u8_lead[3:0], u8_held[0][5:0], b[5:0]});
            else
                v = 64'({u8_lead[2:0], u8_held[0][5:0], u8_held[1][5:0], b[5:0]});
            emit_code(v, 1'b0);
            u8_lead    = '0;
            u8_count   = '0;
            u8_held[0] = '0;
            u8_held[1] = '0;
            return;
        end
        case (esc_state)
            wsld_pkg::ESC_BSL:
            begin
                esc_state = wsld_pkg::ESC_NONE;
                case (b)
                    "n":       emit_code(64'd10, 1'b0);
                    "t":       emit_code(64'd9, 1'b0);
                    "r":       emit_code(64'd13, 1'b0);
                    "a":       emit_code(64'd7, 1'b0);
                    "0":       emit_code(64'd0, 1'b0);
                    BACKSLASH: emit_code(64'd92, 1'b0);
                    8'h27:     emit_code(64'd39, 1'b0);
                    QUOTE:     emit_code(64'd34, 1'b0);
                    "x":
                    begin
                        esc_state = wsld_pkg::ESC_HEX;
                        esc_acc   = '0;
                    end
                    default:
                    begin
                        if (b >= "1" && b <= "7")
                        begin
                            esc_state = wsld_pkg::ESC_OCT;
                            esc_acc   = 64'(b[2:0]);
                            oct_count = 2'd1;
                        end
                        else
                            emit_code(64'(b), 1'b0);
                    end
                endcase
            end
            wsld_pkg::ESC_HEX:
            begin
                d = hex_digit(b);
                if (d >= 0)
                    esc_acc = {esc_acc[59:0], d[3:0]};
                else
                begin
                    emit_code(esc_acc, 1'b0);
                    esc_state = wsld_pkg::ESC_NONE;
                    esc_acc   = '0;
                    decode_plain(b);
                end
            end
            wsld_pkg::ESC_OCT:
            begin
                if (b >= "0" && b <= "7" && oct_count < 2'd3)
                begin
                    esc_acc = {esc_acc[60:0], b[2:0]};
                    oct_count++;
                    if (oct_count == 2'd3)
                    begin
                        emit_code(esc_acc, 1'b0);
                        esc_state = wsld_pkg::ESC_NONE;
                        esc_acc   = '0;
                        oct_count = '0;
                    end
                end
                else
                begin
                    emit_code(esc_acc, 1'b0);
                    esc_state = wsld_pkg::ESC_NONE;
                    esc_acc   = '0;
                    oct_count = '0;
                    decode_plain(b);
                end
            end
            default:
                decode_plain(b);
        endcase
    endfunction

    function automatic void decode_end();
        logic [7:0] h0;
        logic [7:0] h1;
        int         n;
        if (lit_phase == wsld_pkg::PH_SEEK)
            emit_code(64'd0, 1'b1);
        while (lit_phase == wsld_pkg::PH_INSIDE)
        begin
            if (u8_lead != 8'd0)
            begin
                // emit the open lead raw, then replay what it had swallowed
                n  = (u8_count > 2'd2) ? 2 : int'(u8_count);
                h0 = u8_held[0];
                h1 = u8_held[1];
                emit_code(64'(u8_lead), 1'b0);
                u8_lead    = '0;
                u8_count   = '0;
                u8_held[0] = '0;
                u8_held[1] = '0;
                if (n > 0 && lit_phase == wsld_pkg::PH_INSIDE)
                    decode_inside(h0);
                if (n > 1 && lit_phase == wsld_pkg::PH_INSIDE)
                    decode_inside(h1);
                continue;
            end
            if (esc_state == wsld_pkg::ESC_BSL)
                emit_code(64'd92, 1'b0);
            else if (esc_state == wsld_pkg::ESC_HEX || esc_state == wsld_pkg::ESC_OCT)
                emit_code(esc_acc, 1'b0);
            esc_state = wsld_pkg::ESC_NONE;
            emit_code(64'd0, 1'b1);
            lit_phase = wsld_pkg::PH_DONE;
        end
        clear_decoder();
    endfunction

    function automatic void predict_codes(logic k, logic [7:0] b);
        step_codes = 0;
        if (k || b == 8'd0)
            decode_end();
        else if (lit_phase == wsld_pkg::PH_SEEK)
        begin
            if (b == QUOTE)
                lit_phase = wsld_pkg::PH_INSIDE;
        end
        else if (lit_phase == wsld_pkg::PH_INSIDE)
            decode_inside(b);
    endfunction

    function automatic void push_byte(logic [7:0] b, bit drain = 1'b0);
        text_item_t it;
        it.kind  = 1'b0;
        it.ch    = b;
        it.drain = drain;
        pending.insert(pending.size(), it);
    endfunction

    function automatic void push_eot();
        text_item_t it;
        it.kind  = 1'b1;
        it.ch    = 8'($urandom_range(0, 255));
        it.drain = 1'b0;
        pending.insert(pending.size(), it);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 7) == 0)
            return any_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] utf8_lead_of(int len);
        if (len == 2)
            return 8'($urandom_range(8'hC0, 8'hDF));
        if (len == 3)
            return 8'($urandom_range(8'hE0, 8'hEF));
        return 8'($urandom_range(8'hF0, 8'hF7));
    endfunction

    // One literal: optional junk, opening quote, tokens, then some way of ending.
    function automatic void gen_literal(bit drain);
        string      esc_chars;
        string      hex_chars;
        logic [7:0] b;
        int         len;
        esc_chars = "ntra0\\'\"";
        hex_chars = "0123456789abcdefABCDEF";
        repeat ($urandom_range(0, 2))
        begin
            b = any_byte();
            if (b == QUOTE)
                b = "q";
            push_byte(b);
        end
        push_byte(QUOTE, drain);
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 9))
                1:
                begin
                    push_byte(BACKSLASH);
                    push_byte(esc_chars[$urandom_range(0, esc_chars.len() - 1)]);
                end
                2:
                begin
                    push_byte(BACKSLASH);
                    push_byte("x");
                    repeat ($urandom_range(0, 17))
                        push_byte(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
                end
                3:
                begin
                    push_byte(BACKSLASH);
                    push_byte(8'($urandom_range("1", "7")));
                    repeat ($urandom_range(0, 2))
                        push_byte(8'($urandom_range("0", "7")));
                end
                4:
                begin
                    push_byte(BACKSLASH);
                    push_byte(any_byte());
                end
                5, 6:
                begin
                    len = $urandom_range(2, 4);
                    push_byte(utf8_lead_of(len));
                    repeat (len - 1)
                        push_byte(cont_byte());
                end
                7:
                begin
                    if ($urandom_range(0, 1) == 0)
                        push_byte(8'($urandom_range(8'h80, 8'hBF)));
                    else
                        push_byte(8'($urandom_range(8'hF8, 8'hFF)));
                end
                8:
                    push_byte(any_byte());
                default:
                begin
                    do
                        b = 8'($urandom_range(8'h20, 8'h7E));
                    while (b == QUOTE || b == BACKSLASH);
                    push_byte(b);
                end
            endcase
        end
        case ($urandom_range(0, 7))
            4:
                push_eot();
            5:
                push_byte(8'h00);
            6:
            begin
                len = $urandom_range(2, 4);
                push_byte(utf8_lead_of(len));
                repeat ($urandom_range(0, len - 2))
                    push_byte(cont_byte());
                push_eot();
            end
            7:
            begin
                push_byte(BACKSLASH);
                if ($urandom_range(0, 1) == 1)
                begin
                    push_byte("x");
                    repeat ($urandom_range(0, 3))
                        push_byte(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
                end
                push_eot();
            end
            default:
            begin
                push_byte(QUOTE);
                repeat ($urandom_range(0, 2))
                    push_byte(any_byte());
                push_eot();
            end
        endcase
    endfunction

    task automatic check_code(logic [63:0] v, logic l);
        code_t want;
        if (expected_codes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected code_value %h last %b", v, l));
            return;
        end
        want = expected_codes.pop_front();
        if (v !== want.value)
            report_mismatch($sformatf("code_value %h, expected %h", v, want.value));
        if (l !== want.last)
            report_mismatch($sformatf("last %b, expected %b (code_value %h)", l, want.last, v));
    endtask

    // input side
    int         send_gap = 0;
    bit         send_burst = 1'b0;
    text_item_t item_now;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            kind      <= 1'b0;
            text_byte <= 8'h00;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_codes(kind, text_byte);
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() == 0 ||
                         (pending[0].drain && expected_codes.size() != 0))
                    in_valid <= 1'b0;
                else
                begin
                    item_now = pending.pop_front();
                    in_valid  <= 1'b1;
                    kind      <= item_now.kind;
                    text_byte <= item_now.ch;
                    if ($urandom_range(0, 31) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 7);
                end
            end
        end
    end

    // output side
    int codes_seen = 0;
    int hold_left = 0;
    bit recv_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_code(code_value, last);
                codes_seen++;
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
                // long hold-offs let the result queue fill and back up the input
                if (codes_seen == 40 || codes_seen == 150)
                    hold_left = LONG_HOLD;
                else
                    hold_left = recv_burst ? 0 : $urandom_range(0, 7);
                out_ready <= (hold_left == 0);
            end
            else if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= (hold_left == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("wide_string_literal_decoder_unit_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        clear_decoder();

        // skipped prefix, escapes, hex ended by a backslash, three-digit octal,
        // backslash zero then a digit, 3-byte UTF-8, stray and invalid bytes,
        // a quote swallowed as continuation, then end of text replaying it
        push_text("a\"\\n\\xFf9\\177\\05");
        push_byte(8'hE2);
        push_byte(8'h82);
        push_byte(8'hAC);
        push_byte(8'h80);
        push_byte(8'hFF);
        push_byte(8'hF0);
        push_byte(QUOTE);
        push_byte(8'h9F);
        push_eot();
        // end of text with no literal open
        push_eot();
        // dangling backslash closed by a zero byte
        push_text("\"\\");
        push_byte(8'h00);
        // bytes after the closing quote are dropped
        push_text("\"\"x");
        push_eot();

        for (int n = 0; pending.size() < 272; n++)
            gen_literal(n == 4 || n == 20);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_codes.size() != 0)
            report_mismatch($sformatf("%0d codes never arrived", expected_codes.size()));
        if (error_count == 0)
            $display("wide_string_literal_decoder_unit_tb OK");
        else
            $display("wide_string_literal_decoder_unit_tb NOT OK");
        $finish;
    end

endmodule
